@@ src/per_source_token_bucket_limiter_defines.svh @@
// ----------------------------------------------------------------------------
// per_source_token_bucket_limiter_defines
// Assertion macros shared by the limiter RTL. They expect clk and rst_n in
// the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef PER_SOURCE_TOKEN_BUCKET_LIMITER_DEFINES_SVH
`define PER_SOURCE_TOKEN_BUCKET_LIMITER_DEFINES_SVH

// Same-cycle implication.
`define PSTB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PSTB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/pstb_pkg.sv @@
// ----------------------------------------------------------------------------
// pstb_pkg
// Types and constants shared by the per-source token bucket limiter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pstb_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;

    localparam int ADDR_W = 32;
    localparam int TICK_W = 64;
    localparam int TOK_W  = 16;
    localparam int LU_W   = 32;
    localparam int RATE_W = 8;
    localparam int ADD_W  = TOK_W + RATE_W;

    localparam logic [RATE_W-1:0] RATE_RESET  = 8'd1;
    localparam logic [TOK_W-1:0]  BURST_RESET = 16'd10;

    // Register index, taken from paddr[2]
    typedef enum logic
    {
        REG_REFILL_RATE = 1'b0,
        REG_BURST_LIMIT = 1'b1
    } reg_index_t;

    typedef struct packed
    {
        logic [ADDR_W-1:0] key;
        logic [TICK_W-1:0] refill_tick;
        logic [TOK_W-1:0]  tokens;
        logic [LU_W-1:0]   last_use;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed
    {
        logic              allowed;
        logic [TOK_W-1:0]  tokens;
        logic [TICK_W-1:0] refill_tick;
    } bucket_result_t;

endpackage

@@ src/per_source_token_bucket_limiter.sv @@
// A packet word carries a source address and the current tick; one result
// word says whether the packet may pass. The key table sits in one RAM with
// a single read port, so the scan reads one entry per cycle, then the chosen
// slot is read again, refilled and written back. Address zero skips the scan
// and goes straight to the result. The input is not ready while a word is in
// work or a finished result cannot yet be handed off. The table is empty
// after reset at once, tracked by one valid flop per entry.
// ----------------------------------------------------------------------------
// per_source_token_bucket_limiter
// Per-source token bucket rate limiter with LRU replacement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "per_source_token_bucket_limiter_defines.svh"

module per_source_token_bucket_limiter
    import pstb_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    // stream in
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // [31:0] source_address, [95:32] now_tick
    // stream out
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,   // [0] allowed, [7:1] zero
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int IW = $clog2(TABLE_ENTRIES);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_READ,
        ST_CALC1,
        ST_CALC2,
        ST_DONE
    } state_t;

    state_t              state_reg,   state_next;
    logic [IW-1:0]       issue_reg,   issue_next;
    logic                cmp_en_reg,  cmp_en_next;
    logic [IW-1:0]       cmp_idx_reg, cmp_idx_next;
    logic [ADDR_W-1:0]   addr_reg,    addr_next;
    logic [TICK_W-1:0]   now_reg,     now_next;
    logic                hit_reg,     hit_next;
    logic [IW-1:0]       slot_reg,    slot_next;
    logic                allowed_reg, allowed_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_allowed_reg, out_allowed_next;
    logic [RATE_W-1:0]   rate_reg;
    logic [TOK_W-1:0]    burst_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic                rd_valid_reg;

    logic                in_accept;
    logic                cfg_write;
    logic [IW-1:0]       rd_addr;
    logic [ENTRY_W-1:0]  rd_raw;
    entry_t              rd_entry;
    entry_t              wr_entry;
    logic                wr_en;
    logic                scan_clear;
    logic                scan_hit;
    logic [IW-1:0]       scan_slot;
    logic                bucket_load;
    logic [TOK_W-1:0]    base_tokens;
    logic [TICK_W-1:0]   base_tick;
    bucket_result_t      bucket_res;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {7'b0, out_allowed_reg};

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg  <= RATE_RESET;
            burst_reg <= BURST_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_index_t'(paddr[2]))
                REG_REFILL_RATE: rate_reg  <= pwdata[RATE_W-1:0];
                REG_BURST_LIMIT: burst_reg <= pwdata[TOK_W-1:0];
                default:         rate_reg  <= rate_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index_t'(paddr[2]))
            REG_REFILL_RATE: prdata = {{(32 - RATE_W){1'b0}}, rate_reg};
            REG_BURST_LIMIT: prdata = {{(32 - TOK_W){1'b0}}, burst_reg};
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Table storage
    // ------------------------------------------------------------------
    assign rd_addr = (state_reg == ST_SCAN) ? issue_reg : scan_slot;
    assign wr_en   = (state_reg == ST_CALC2);

    always_comb
    begin
        wr_entry.key         = addr_reg;
        wr_entry.refill_tick = bucket_res.refill_tick;
        wr_entry.tokens      = bucket_res.tokens;
        wr_entry.last_use    = now_reg[LU_W-1:0];
    end

    pstb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (slot_reg),
        .wr_data (wr_entry),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    // Entries never written read as free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[rd_addr];
            if (wr_en)
            begin
                valid_reg[slot_reg] <= 1'b1;
            end
        end
    end

    assign rd_entry = rd_valid_reg ? entry_t'(rd_raw) : '0;

    // ------------------------------------------------------------------
    // Scan and bucket units
    // ------------------------------------------------------------------
    assign scan_clear = in_accept;

    pstb_scan #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (scan_clear),
        .cmp_en   (cmp_en_reg),
        .cmp_idx  (cmp_idx_reg),
        .key      (rd_entry.key),
        .last_use (rd_entry.last_use),
        .addr     (addr_reg),
        .hit      (scan_hit),
        .slot     (scan_slot)
    );

    // A new entry starts full with its refill tick at now
    assign bucket_load = (state_reg == ST_CALC1);
    assign base_tokens = hit_reg ? rd_entry.tokens : burst_reg;
    assign base_tick   = hit_reg ? rd_entry.refill_tick : now_reg;

    pstb_bucket u_bucket (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (bucket_load),
        .base_tokens (base_tokens),
        .base_tick   (base_tick),
        .now_tick    (now_reg),
        .refill_rate (rate_reg),
        .burst_limit (burst_reg),
        .result      (bucket_res)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        issue_next       = issue_reg;
        cmp_en_next      = (state_reg == ST_SCAN);
        cmp_idx_next     = issue_reg;
        addr_next        = addr_reg;
        now_next         = now_reg;
        hit_next         = hit_reg;
        slot_next        = slot_reg;
        allowed_next     = allowed_reg;
        out_valid_next   = out_valid_reg;
        out_allowed_next = out_allowed_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    addr_next  = s_tdata[ADDR_W-1:0];
                    now_next   = s_tdata[ADDR_W +: TICK_W];
                    issue_next = '0;
                    if (s_tdata[ADDR_W-1:0] == '0)
                    begin
                        // Zero address: deny, touch nothing
                        allowed_next = 1'b0;
                        state_next   = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                issue_next = issue_reg + IW'(1);
                if (issue_reg == IW'(TABLE_ENTRIES - 1))
                begin
                    state_next = ST_SCAN_LAST;
                end
            end
            ST_SCAN_LAST:
            begin
                state_next = ST_READ;
            end
            ST_READ:
            begin
                hit_next   = scan_hit;
                slot_next  = scan_slot;
                state_next = ST_CALC1;
            end
            ST_CALC1:
            begin
                state_next = ST_CALC2;
            end
            ST_CALC2:
            begin
                allowed_next = bucket_res.allowed;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next   = 1'b1;
                    out_allowed_next = allowed_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            issue_reg       <= '0;
            cmp_en_reg      <= 1'b0;
            cmp_idx_reg     <= '0;
            addr_reg        <= '0;
            now_reg         <= '0;
            hit_reg         <= 1'b0;
            slot_reg        <= '0;
            allowed_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_allowed_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            issue_reg       <= issue_next;
            cmp_en_reg      <= cmp_en_next;
            cmp_idx_reg     <= cmp_idx_next;
            addr_reg        <= addr_next;
            now_reg         <= now_next;
            hit_reg         <= hit_next;
            slot_reg        <= slot_next;
            allowed_reg     <= allowed_next;
            out_valid_reg   <= out_valid_next;
            out_allowed_reg <= out_allowed_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PSTB_ASSERT_NEXT(a_busy_after_accept, in_accept, !s_tready, "ready after accept")
    `PSTB_ASSERT_NEXT(a_zero_addr_denied,
        in_accept && s_tdata[ADDR_W-1:0] == '0,
        state_reg == ST_DONE && !allowed_reg, "zero address not denied")
    `PSTB_ASSERT_NOW(a_result_from_done,
        $rose(m_tvalid), $past(state_reg == ST_DONE), "result outside done")
    `PSTB_ASSERT_NOW(a_write_not_scanning,
        wr_en, !cmp_en_reg && state_reg != ST_SCAN, "table write during scan")

endmodule

@@ src/pstb_ram.sv @@
// ----------------------------------------------------------------------------
// pstb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pstb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ src/pstb_scan.sv @@
// ----------------------------------------------------------------------------
// pstb_scan
// Shared compare unit for the table scan: finds the matching key, the first
// free slot and the least recently used entry, one entry per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pstb_scan
    import pstb_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             clear,
    input  logic                             cmp_en,
    input  logic [$clog2(TABLE_ENTRIES)-1:0] cmp_idx,
    input  logic [ADDR_W-1:0]                key,
    input  logic [LU_W-1:0]                  last_use,
    input  logic [ADDR_W-1:0]                addr,
    output logic                             hit,
    output logic [$clog2(TABLE_ENTRIES)-1:0] slot
);

    localparam int IW = $clog2(TABLE_ENTRIES);

    logic          hit_reg,      hit_next;
    logic [IW-1:0] hit_idx_reg,  hit_idx_next;
    logic          free_reg,     free_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic [LU_W-1:0] oldest_reg, oldest_next;
    logic [IW-1:0] victim_reg,   victim_next;
    logic [LU_W-1:0] age_diff;

    assign age_diff = last_use - oldest_reg;

    always_comb
    begin
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        oldest_next   = oldest_reg;
        victim_next   = victim_reg;
        if (clear)
        begin
            hit_next  = 1'b0;
            free_next = 1'b0;
        end
        else if (cmp_en)
        begin
            if (key == addr)
            begin
                hit_next     = 1'b1;
                hit_idx_next = cmp_idx;
            end
            if (!free_reg && key == '0)
            begin
                free_next     = 1'b1;
                free_idx_next = cmp_idx;
            end
            // Entry zero seeds the age search; later entries win only if strictly older
            if (cmp_idx == '0 || age_diff[LU_W-1])
            begin
                oldest_next = last_use;
                victim_next = cmp_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg      <= 1'b0;
            hit_idx_reg  <= '0;
            free_reg     <= 1'b0;
            free_idx_reg <= '0;
            oldest_reg   <= '0;
            victim_reg   <= '0;
        end
        else
        begin
            hit_reg      <= hit_next;
            hit_idx_reg  <= hit_idx_next;
            free_reg     <= free_next;
            free_idx_reg <= free_idx_next;
            oldest_reg   <= oldest_next;
            victim_reg   <= victim_next;
        end
    end

    assign hit  = hit_reg;
    assign slot = hit_reg ? hit_idx_reg : (free_reg ? free_idx_reg : victim_reg);

endmodule

@@ src/pstb_bucket.sv @@
// ----------------------------------------------------------------------------
// pstb_bucket
// Two-stage bucket update: refill amount, then cap and token consume.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pstb_bucket
    import pstb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic [TOK_W-1:0]    base_tokens,
    input  logic [TICK_W-1:0]   base_tick,
    input  logic [TICK_W-1:0]   now_tick,
    input  logic [RATE_W-1:0]   refill_rate,
    input  logic [TOK_W-1:0]    burst_limit,
    output bucket_result_t      result
);

    logic [TICK_W-1:0] elapsed;
    logic [ADD_W-1:0]  add_calc;
    logic [TOK_W-1:0]  tok_reg;
    logic [TICK_W-1:0] tick_reg;
    logic              elapsed_nz_reg;
    logic [ADD_W-1:0]  add_reg;
    logic [ADD_W:0]    sum;
    logic [TOK_W-1:0]  capped;
    logic [TOK_W-1:0]  refilled;

    assign elapsed = now_tick - base_tick;

    always_comb
    begin
        if (refill_rate == '0)
        begin
            add_calc = '0;
        end
        else if (|elapsed[TICK_W-1:TOK_W])
        begin
            // Saturate: one full bucket range is always enough
            add_calc = ADD_W'(1) << TOK_W;
        end
        else
        begin
            add_calc = elapsed[TOK_W-1:0] * refill_rate;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg        <= '0;
            tick_reg       <= '0;
            elapsed_nz_reg <= 1'b0;
            add_reg        <= '0;
        end
        else if (load)
        begin
            tok_reg        <= base_tokens;
            tick_reg       <= base_tick;
            elapsed_nz_reg <= |elapsed;
            add_reg        <= add_calc;
        end
    end

    assign sum      = {{(ADD_W + 1 - TOK_W){1'b0}}, tok_reg} + {1'b0, add_reg};
    assign capped   = (sum > {{(ADD_W + 1 - TOK_W){1'b0}}, burst_limit}) ? burst_limit
                                                                         : sum[TOK_W-1:0];
    assign refilled = elapsed_nz_reg ? capped : tok_reg;

    always_comb
    begin
        result.allowed     = (refilled != '0);
        result.tokens      = (refilled != '0) ? refilled - TOK_W'(1) : refilled;
        result.refill_tick = elapsed_nz_reg ? now_tick : tick_reg;
    end

endmodule
